@@ hdl/aggms_pkg.sv @@
`default_nettype none

package aggms_pkg;

    typedef enum logic [2:0]
    {
        PH_TYPE    = 3'd0,
        PH_SIZE    = 3'd1,
        PH_TS      = 3'd2,
        PH_TSEXT   = 3'd3,
        PH_SID     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_TRAILER = 3'd6
    } phase_t;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ERR_HEADER  = 2'd0;
    localparam logic [1:0] ERR_PAYLOAD = 2'd1;
    localparam logic [1:0] ERR_TRAILER = 2'd2;

    localparam logic [7:0] TYPE_AUDIO = 8'd8;
    localparam logic [7:0] TYPE_VIDEO = 8'd9;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef struct packed
    {
        logic [1:0]  kind;
        logic [7:0]  sub_type;
        logic [23:0] body_length;
        logic [23:0] stream_ident;
        logic [30:0] raw_timestamp;
        logic [33:0] rebased_timestamp;
        logic [7:0]  payload_data;
        logic        payload_end;
        logic [1:0]  error_code;
        logic        run_last;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/aggms_parser.sv @@
`default_nettype none

module aggms_parser
    import aggms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    input  wire logic [31:0] parent_timestamp,
    output result_t          res0,
    output result_t          res1,
    output logic [1:0]       res_count
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [7:0]  type_reg, type_next;
    logic [23:0] rem_reg, rem_next;
    logic [30:0] ts_reg, ts_next;
    logic [23:0] sid_reg, sid_next;
    logic [30:0] base_reg, base_next;
    logic        first_reg, first_next;
    logic        keep_reg, keep_next;

    logic [23:0] rem_dec;
    logic [23:0] sid_shift;
    logic        keep_type;
    logic [33:0] rebased;

    assign rem_dec   = rem_reg - 24'd1;
    assign sid_shift = {sid_reg[15:0], data_byte};
    assign keep_type = (type_reg == TYPE_AUDIO) || (type_reg == TYPE_VIDEO);
    assign rebased   = {2'b00, parent_timestamp} + {3'b000, ts_reg} - {3'b000, base_reg};

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_SIZE:
            begin
                if (cnt_reg == 2'd2)
                begin
                    phase_next = PH_TS;
                end
            end
            PH_TS:
            begin
                if (cnt_reg == 2'd2)
                begin
                    phase_next = PH_TSEXT;
                end
            end
            PH_TSEXT:
            begin
                phase_next = PH_SID;
            end
            PH_SID:
            begin
                if (cnt_reg == 2'd2)
                begin
                    phase_next = (rem_reg != 24'd0) ? PH_PAYLOAD : PH_TRAILER;
                end
            end
            PH_PAYLOAD:
            begin
                if (rem_dec == 24'd0)
                begin
                    phase_next = PH_TRAILER;
                end
            end
            PH_TRAILER:
            begin
                if (cnt_reg == 2'd3)
                begin
                    phase_next = PH_TYPE;
                end
            end
            default:
            begin
                phase_next = PH_SIZE;
            end
        endcase
        if (last_byte)
        begin
            phase_next = PH_TYPE;
        end
    end

    always_comb
    begin
        result_t    main_res;
        logic       main_valid;
        logic       err_valid;
        logic [1:0] err_code;
        result_t    err_res;

        cnt_next   = cnt_reg;
        type_next  = type_reg;
        rem_next   = rem_reg;
        ts_next    = ts_reg;
        sid_next   = sid_reg;
        base_next  = base_reg;
        first_next = first_reg;
        keep_next  = keep_reg;
        main_res   = '0;
        main_valid = 1'b0;
        err_valid  = last_byte;
        err_code   = ERR_HEADER;
        err_res    = '0;

        unique case (phase_reg)
            PH_SIZE:
            begin
                rem_next = {rem_reg[15:0], data_byte};
                cnt_next = (cnt_reg == 2'd2) ? 2'd0 : cnt_reg + 2'd1;
            end
            PH_TS:
            begin
                ts_next  = {7'd0, ts_reg[15:0], data_byte};
                cnt_next = (cnt_reg == 2'd2) ? 2'd0 : cnt_reg + 2'd1;
            end
            PH_TSEXT:
            begin
                ts_next  = {data_byte[6:0], ts_reg[23:0]};
                cnt_next = 2'd0;
                if (first_reg)
                begin
                    base_next  = {data_byte[6:0], ts_reg[23:0]};
                    first_next = 1'b0;
                end
            end
            PH_SID:
            begin
                sid_next = sid_shift;
                if (cnt_reg == 2'd2)
                begin
                    cnt_next                   = 2'd0;
                    keep_next                  = keep_type;
                    main_valid                 = keep_type;
                    main_res.kind              = KIND_HEADER;
                    main_res.sub_type          = type_reg;
                    main_res.body_length       = rem_reg;
                    main_res.stream_ident      = sid_shift;
                    main_res.raw_timestamp     = ts_reg;
                    main_res.rebased_timestamp = rebased;
                    err_code = (rem_reg != 24'd0) ? ERR_PAYLOAD : ERR_TRAILER;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            PH_PAYLOAD:
            begin
                main_valid            = keep_reg;
                main_res.kind         = KIND_PAYLOAD;
                main_res.payload_data = data_byte;
                main_res.payload_end  = (rem_reg == 24'd1);
                rem_next              = rem_dec;
                if (rem_dec == 24'd0)
                begin
                    cnt_next = 2'd0;
                end
                err_code = (rem_dec != 24'd0) ? ERR_PAYLOAD : ERR_TRAILER;
            end
            PH_TRAILER:
            begin
                cnt_next = cnt_reg + 2'd1;
                err_code = ERR_TRAILER;
                if (cnt_reg == 2'd3)
                begin
                    err_valid = 1'b0;
                end
            end
            default:
            begin
                type_next = data_byte;
                rem_next  = 24'd0;
                ts_next   = 31'd0;
                sid_next  = 24'd0;
                cnt_next  = 2'd0;
            end
        endcase

        if (last_byte)
        begin
            cnt_next   = 2'd0;
            first_next = 1'b1;
            keep_next  = 1'b0;
        end

        err_res.kind       = KIND_ERROR;
        err_res.error_code = err_code;
        err_res.run_last   = 1'b1;
        main_res.run_last  = !err_valid;

        res1 = err_res;
        if (main_valid)
        begin
            res0 = main_res;
        end
        else
        begin
            res0 = err_res;
        end
        res_count = {1'b0, main_valid} + {1'b0, err_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            cnt_reg   <= 2'd0;
            type_reg  <= 8'd0;
            rem_reg   <= 24'd0;
            ts_reg    <= 31'd0;
            sid_reg   <= 24'd0;
            base_reg  <= 31'd0;
            first_reg <= 1'b1;
            keep_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            type_reg  <= type_next;
            rem_reg   <= rem_next;
            ts_reg    <= ts_next;
            sid_reg   <= sid_next;
            base_reg  <= base_next;
            first_reg <= first_next;
            keep_reg  <= keep_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/aggregate_message_splitter.sv @@
// Channel   Direction  Content
// s_axis    in         tdata: data_byte, parent_timestamp; tlast: last_byte
// m_axis    out        tdata: sub-message fields; tuser: result_kind; tlast: run_last
//
// An input item can be taken every cycle while the result queue has room; each causes zero, one or two result items.
// An item passes an input register, then the parser, then a four-entry result
// queue; the first result is offered once the parser has written it into that queue.
// Input stalls only when the result queue has fewer than two free entries.
// Reset puts the parser at the start of an aggregate message; no clearing pass.
`default_nettype none

module aggregate_message_splitter
    import aggms_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // data_byte [7:0], parent_timestamp [39:8]
    input  wire logic [39:0]  s_axis_tdata,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // sub-message type, payload size, stream_ident, raw_timestamp,
    // rebased_timestamp, payload_data, payload_end, error_code, zero fill
    output logic [135:0]      m_axis_tdata,
    // result_kind
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    logic [31:0]          in_parent_reg;

    result_t              fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;

    logic                 advance;
    logic                 pop;
    logic                 s_accept;
    logic [1:0]           push_count;
    result_t              res0;
    result_t              res1;
    logic [1:0]           res_count;
    result_t              head;

    assign advance       = in_valid_reg && (count_reg <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (count_reg != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign push_count    = advance ? res_count : 2'd0;

    aggms_parser u_parser
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .data_byte        (in_byte_reg),
        .last_byte        (in_last_reg),
        .parent_timestamp (in_parent_reg),
        .res0             (res0),
        .res1             (res1),
        .res_count        (res_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push_count);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (FIFO_AW + 1)'(push_count) - (FIFO_AW + 1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg   <= s_axis_tdata[7:0];
            in_last_reg   <= s_axis_tlast;
            in_parent_reg <= s_axis_tdata[39:8];
        end
        if (push_count != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (push_count == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + 1'b1] <= res1;
        end
    end

    assign head = fifo_reg[rd_ptr_reg];

    assign m_axis_tdata[7:0]     = head.sub_type;
    assign m_axis_tdata[31:8]    = head.body_length;
    assign m_axis_tdata[55:32]   = head.stream_ident;
    assign m_axis_tdata[86:56]   = head.raw_timestamp;
    assign m_axis_tdata[120:87]  = head.rebased_timestamp;
    assign m_axis_tdata[128:121] = head.payload_data;
    assign m_axis_tdata[129]     = head.payload_end;
    assign m_axis_tdata[131:130] = head.error_code;
    assign m_axis_tdata[135:132] = 4'd0;
    assign m_axis_tuser          = head.kind;
    assign m_axis_tlast          = head.run_last;

endmodule

`default_nettype wire

@@ dv/aggregate_message_splitter_tb.sv @@
`timescale 1ns / 1ps

module aggregate_message_splitter_tb
    import aggms_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned RANDOM_BYTES = 800;
    localparam int unsigned DRAIN_CYCLES = 20;

    logic         clk;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    aggregate_message_splitter dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Parser state kept alongside the block.
    phase_t      phase = PH_TYPE;
    int          field_count = 0;
    logic [7:0]  cur_type = '0;
    logic [23:0] remaining = '0;
    logic [31:0] ts_acc = '0;
    logic [23:0] sid_acc = '0;
    logic [30:0] base_ts = '0;
    logic        need_base = 1'b1;
    logic        keep = 1'b0;

    result_t     sub_message_results[$];
    int          mismatches = 0;
    int unsigned bytes_sent = 0;
    bit          src_idle = 1'b0;
    bit          sink_idle = 1'b0;
    int          sink_hold = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic lst,
                                       input logic [31:0] parent);
        result_t    made[$];
        result_t    r;
        logic       has_err;
        logic [1:0] err_code;
        has_err = 1'b0;
        err_code = ERR_HEADER;
        case (phase)
            PH_SIZE:
            begin
                remaining = {remaining[15:0], b};
                field_count++;
                if (field_count == 3)
                begin
                    field_count = 0;
                    phase = PH_TS;
                end
                has_err = lst;
            end
            PH_TS:
            begin
                ts_acc = {8'd0, ts_acc[15:0], b};
                field_count++;
                if (field_count == 3)
                begin
                    field_count = 0;
                    phase = PH_TSEXT;
                end
                has_err = lst;
            end
            PH_TSEXT:
            begin
                ts_acc = {1'b0, b[6:0], ts_acc[23:0]};
                if (need_base)
                begin
                    base_ts = ts_acc[30:0];
                    need_base = 1'b0;
                end
                phase = PH_SID;
                field_count = 0;
                has_err = lst;
            end
            PH_SID:
            begin
                sid_acc = {sid_acc[15:0], b};
                field_count++;
                if (field_count < 3)
                begin
                    has_err = lst;
                end
                else
                begin
                    field_count = 0;
                    keep = (cur_type == TYPE_AUDIO) || (cur_type == TYPE_VIDEO);
                    if (keep)
                    begin
                        r = '0;
                        r.kind = KIND_HEADER;
                        r.sub_type = cur_type;
                        r.body_length = remaining;
                        r.stream_ident = sid_acc;
                        r.raw_timestamp = ts_acc[30:0];
                        r.rebased_timestamp = {2'b00, parent} + {3'b000, ts_acc[30:0]}
                                              - {3'b000, base_ts};
                        made.insert(made.size(), r);
                    end
                    phase = (remaining != 0) ? PH_PAYLOAD : PH_TRAILER;
                    has_err = lst;
                    err_code = (remaining != 0) ? ERR_PAYLOAD : ERR_TRAILER;
                end
            end
            PH_PAYLOAD:
            begin
                if (keep)
                begin
                    r = '0;
                    r.kind = KIND_PAYLOAD;
                    r.payload_data = b;
                    r.payload_end = (remaining == 24'd1);
                    made.insert(made.size(), r);
                end
                remaining = remaining - 24'd1;
                if (remaining == 0)
                begin
                    phase = PH_TRAILER;
                    field_count = 0;
                end
                has_err = lst;
                err_code = (remaining != 0) ? ERR_PAYLOAD : ERR_TRAILER;
            end
            PH_TRAILER:
            begin
                field_count++;
                if (field_count >= 4)
                begin
                    field_count = 0;
                    phase = PH_TYPE;
                end
                else
                begin
                    has_err = lst;
                    err_code = ERR_TRAILER;
                end
            end
            default:
            begin
                cur_type = b;
                remaining = '0;
                ts_acc = '0;
                sid_acc = '0;
                field_count = 0;
                phase = PH_SIZE;
                has_err = lst;
            end
        endcase
        if (has_err)
        begin
            r = '0;
            r.kind = KIND_ERROR;
            r.error_code = err_code;
            made.insert(made.size(), r);
        end
        if (made.size() > 0)
            made[made.size() - 1].run_last = 1'b1;
        foreach (made[i])
            sub_message_results.insert(sub_message_results.size(), made[i]);
        if (lst)
        begin
            phase = PH_TYPE;
            field_count = 0;
            need_base = 1'b1;
            keep = 1'b0;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lst, input logic [31:0] parent);
        int gap;
        gap = src_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {parent, b};
        s_axis_tlast <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        parse_byte(b, lst, parent);
        bytes_sent++;
    endtask

    function automatic void add_sub_message(ref logic [7:0] msg[$], input logic [7:0] kind,
                                            input logic [23:0] len, input logic [31:0] stamp,
                                            input logic [23:0] stream, input bit with_body);
        msg.insert(msg.size(), kind);
        for (int i = 2; i >= 0; i--)
            msg.insert(msg.size(), len[8*i +: 8]);
        for (int i = 2; i >= 0; i--)
            msg.insert(msg.size(), stamp[8*i +: 8]);
        msg.insert(msg.size(), stamp[31:24]);
        for (int i = 2; i >= 0; i--)
            msg.insert(msg.size(), stream[8*i +: 8]);
        if (with_body)
        begin
            repeat (len) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
            repeat (4) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_frame(ref logic [7:0] msg[$], input logic [31:0] parent,
                              input int n_bytes);
        for (int i = 0; i < n_bytes; i++)
            send_byte(msg[i], i == n_bytes - 1, parent);
    endtask

    task automatic test_directed();
        logic [7:0] msg[$];
        src_idle = 1'b0;
        sink_idle = 1'b0;
        // An aggregate message that ends on its first type byte.
        msg = '{TYPE_AUDIO};
        send_frame(msg, 32'h0, 1);
        // Empty audio sub-message with timestamp and stream ident at their maximum, cut in the trailer.
        msg.delete();
        add_sub_message(msg, TYPE_AUDIO, 24'd0, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1);
        send_frame(msg, 32'hFFFF_FFFF, 13);
        // Largest declared size, cut right after the header.
        msg.delete();
        add_sub_message(msg, TYPE_VIDEO, 24'hFF_FFFF, 32'h0, 24'h0, 1'b0);
        send_frame(msg, 32'h0, msg.size());
        // A dropped type sets the base; the next one is earlier and ends on its last
        // payload byte, so its rebased time goes negative.
        msg.delete();
        add_sub_message(msg, 8'h12, 24'd0, 32'hFF00_0000, 24'h00_0001, 1'b1);
        add_sub_message(msg, TYPE_AUDIO, 24'd1, 32'h0, 24'h00_0002, 1'b1);
        send_frame(msg, 32'h5, msg.size() - 4);
    endtask

    task automatic test_backpressure();
        logic [7:0] msg[$];
        src_idle = 1'b0;
        sink_idle = 1'b0;
        sink_hold = 300;
        add_sub_message(msg, TYPE_VIDEO, 24'd40, $urandom,
                        24'($urandom_range(0, 24'hFF_FFFF)), 1'b1);
        add_sub_message(msg, TYPE_AUDIO, 24'd20, $urandom,
                        24'($urandom_range(0, 24'hFF_FFFF)), 1'b1);
        send_frame(msg, $urandom, msg.size());
    endtask

    task automatic test_random_messages();
        logic [7:0] msg[$];
        logic [7:0] kind;
        int         shape;
        int         len;
        int         cut;
        int         pick;
        while (bytes_sent < RANDOM_BYTES)
        begin
            msg.delete();
            src_idle = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            shape = $urandom_range(0, 9);
            if (shape == 0)
            begin
                repeat ($urandom_range(1, 24)) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
                cut = msg.size();
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                        kind = TYPE_AUDIO;
                    else if (pick < 8)
                        kind = TYPE_VIDEO;
                    else
                        kind = 8'($urandom_range(0, 255));
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(0, 12);
                    add_sub_message(msg, kind, 24'(len), $urandom,
                                    24'($urandom_range(0, 24'hFF_FFFF)), 1'b1);
                end
                cut = msg.size();
                if (shape <= 2)
                    cut = $urandom_range(1, msg.size() - 1);
            end
            send_frame(msg, $urandom, cut);
        end
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (sink_hold != 0)
            begin
                stall_left = sink_hold;
                sink_hold = 0;
            end
            else if (stall_left == 0 && sink_idle && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
            end
            if (stall_left != 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic void flag_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, what);
    endfunction

    function automatic void check_field(string what, logic [33:0] want, logic [33:0] got);
        if (want !== got)
            flag_mismatch($sformatf("%s mismatch: expected %h, got %h", what, want, got));
    endfunction

    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (sub_message_results.size() == 0)
                begin
                    flag_mismatch("result item arrived with nothing expected");
                end
                else
                begin
                    want = sub_message_results.pop_front();
                    check_field("result_kind", 34'(want.kind), 34'(m_axis_tuser));
                    check_field("sub_type", 34'(want.sub_type), 34'(m_axis_tdata[0 +: 8]));
                    check_field("body_length", 34'(want.body_length),
                                34'(m_axis_tdata[8 +: 24]));
                    check_field("stream_ident", 34'(want.stream_ident),
                                34'(m_axis_tdata[32 +: 24]));
                    check_field("raw_timestamp", 34'(want.raw_timestamp),
                                34'(m_axis_tdata[56 +: 31]));
                    check_field("rebased_timestamp", want.rebased_timestamp,
                                m_axis_tdata[87 +: 34]);
                    check_field("payload_data", 34'(want.payload_data),
                                34'(m_axis_tdata[121 +: 8]));
                    check_field("payload_end", 34'(want.payload_end), 34'(m_axis_tdata[129]));
                    check_field("error_code", 34'(want.error_code),
                                34'(m_axis_tdata[130 +: 2]));
                    check_field("run_last", 34'(want.run_last), 34'(m_axis_tlast));
                end
            end
        end
    end

    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("aggregate_message_splitter regression: fail");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_messages();
        s_axis_tvalid <= 1'b0;
        while (sub_message_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && sub_message_results.size() == 0)
            $display("aggregate_message_splitter regression: pass");
        else
            $display("aggregate_message_splitter regression: fail");
        $finish;
    end

endmodule
